// ===== rtl/rws_pkg.sv =====
// rws_pkg: sizes, codes and control structs of the roulette wheel selector
// used by rws_alu, rws_dp, rws_ctrl and roulette_wheel_selector_top
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

  localparam int POP_MAX      = 1024;
  localparam int FITNESS_BITS = 32;
  localparam int DRAW_BITS    = 16;
  localparam int CONV_BITS    = 16;

  localparam int IDX_W  = $clog2(POP_MAX);
  localparam int CNT_W  = $clog2(POP_MAX + 1);
  localparam int CUM_W  = FITNESS_BITS + IDX_W;
  localparam int THR_W  = CUM_W + DRAW_BITS;
  localparam int ALU_W  = (THR_W > FITNESS_BITS + 1) ? THR_W : FITNESS_BITS + 1;
  localparam int STEP_W = $clog2(CONV_BITS);
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    STAT_SUMMARY    = 3'd0,
    STAT_SELECTED   = 3'd1,
    STAT_ZERO       = 3'd2,
    STAT_NOT_LOADED = 3'd3,
    STAT_OVERFLOW   = 3'd4
  } stat_code_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DRAW = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BUILD,
    ST_DIV,
    ST_MUL,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_ACC,
    SEL_DIV,
    SEL_CMP
  } alu_sel_t;

  typedef struct packed {
    logic             load_we;
    logic             first;
    logic [IDX_W-1:0] load_idx;
    logic             fit_rd;
    logic             cum_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             acc_en;
    logic [IDX_W-1:0] acc_idx;
    logic             sum_clr;
    logic             close;
    logic             div_step;
    logic             mul_en;
    alu_sel_t         alu_sel;
  } dp_ctl_t;

  typedef struct packed {
    logic hit;
    logic total_zero;
  } dp_sts_t;

  typedef struct packed {
    logic             load;
    stat_code_t       code;
    logic             summary;
    logic [IDX_W-1:0] sel_idx;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/rws_alu.sv =====
// rws_alu: shared add/subtract unit with carry out
// depends on rws_pkg for the unit width
`timescale 1ns / 1ps
`default_nettype none

module rws_alu
  import rws_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] res,
  output logic             carry
);

  logic [ALU_W:0] full;

  // carry set on subtract means a >= b
  assign full  = {1'b0, a} + {1'b0, b ^ {ALU_W{sub}}} + {{ALU_W{1'b0}}, sub};
  assign res   = full[ALU_W-1:0];
  assign carry = full[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/rws_dp.sv =====
// rws_dp: fitness and cumulative stores, min/max/best registers, divider and
// draw threshold registers around the shared rws_alu; depends on rws_pkg
`timescale 1ns / 1ps
`default_nettype none

module rws_dp
  import rws_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_ctl_t                 ctl,
  input  logic [FITNESS_BITS-1:0] item_fit,
  input  logic [DRAW_BITS-1:0]    item_rnd,
  output dp_sts_t                 sts,
  output logic [FITNESS_BITS-1:0] min_fit,
  output logic [IDX_W-1:0]        min_idx,
  output logic [FITNESS_BITS-1:0] max_fit,
  output logic [IDX_W-1:0]        max_idx,
  output logic [FITNESS_BITS-1:0] best_fit,
  output logic [CONV_BITS-1:0]    conv
);

  logic [FITNESS_BITS-1:0] fit_mem [POP_MAX];
  logic [CUM_W-1:0]        cum_mem [POP_MAX];
  logic [FITNESS_BITS-1:0] fit_q;
  logic [CUM_W-1:0]        cum_q;

  logic [FITNESS_BITS-1:0] min_r, min_nxt, max_r, max_nxt, best_r, best_nxt;
  logic [IDX_W-1:0]        min_idx_r, min_idx_nxt, max_idx_r, max_idx_nxt;
  logic [CUM_W-1:0]        sum_r, sum_nxt, total_r, total_nxt;
  logic [FITNESS_BITS-1:0] rem_r, rem_nxt;
  logic [CONV_BITS-1:0]    quo_r, quo_nxt;
  logic [THR_W-1:0]        thr_r;

  logic [FITNESS_BITS-1:0] weight;
  logic [FITNESS_BITS:0]   rem_shift;
  logic [ALU_W-1:0]        alu_a, alu_b, alu_res;
  logic                    alu_sub, alu_carry;

  always_ff @(posedge clk) begin
    if (ctl.load_we) begin
      fit_mem[ctl.load_idx] <= item_fit;
    end
    if (ctl.fit_rd) begin
      fit_q <= fit_mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      cum_mem[ctl.acc_idx] <= alu_res[CUM_W-1:0];
    end
    if (ctl.cum_rd) begin
      cum_q <= cum_mem[ctl.rd_addr];
    end
  end

  assign weight    = max_r - fit_q;
  assign rem_shift = {rem_r, 1'b0};

  always_comb begin
    case (ctl.alu_sel)
      SEL_ACC: begin
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(weight);
        alu_sub = 1'b0;
      end
      SEL_DIV: begin
        alu_a   = ALU_W'(rem_shift);
        alu_b   = ALU_W'(max_r);
        alu_sub = 1'b1;
      end
      SEL_CMP: begin
        // threshold minus scaled cumulative weight, borrow means the entry passes
        alu_a   = ALU_W'(thr_r);
        alu_b   = ALU_W'({cum_q, {DRAW_BITS{1'b0}}});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  rws_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  always_comb begin
    min_nxt     = min_r;
    max_nxt     = max_r;
    min_idx_nxt = min_idx_r;
    max_idx_nxt = max_idx_r;
    best_nxt    = best_r;
    sum_nxt     = sum_r;
    total_nxt   = total_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;

    if (ctl.load_we) begin
      if (ctl.first) begin
        min_nxt     = item_fit;
        max_nxt     = item_fit;
        min_idx_nxt = '0;
        max_idx_nxt = '0;
      end else if (item_fit < min_r) begin
        min_nxt     = item_fit;
        min_idx_nxt = ctl.load_idx;
      end else if (item_fit > max_r) begin
        max_nxt     = item_fit;
        max_idx_nxt = ctl.load_idx;
      end
    end

    if (ctl.sum_clr) begin
      sum_nxt = '0;
    end else if (ctl.acc_en) begin
      sum_nxt = alu_res[CUM_W-1:0];
    end

    if (ctl.close) begin
      total_nxt = sum_r;
      if (min_r < best_r) begin
        best_nxt = min_r;
      end
      rem_nxt = max_r - min_r;
      quo_nxt = '0;
    end else if (ctl.div_step) begin
      // one restoring step per cycle
      if (alu_carry) begin
        rem_nxt = alu_res[FITNESS_BITS-1:0];
      end else begin
        rem_nxt = rem_shift[FITNESS_BITS-1:0];
      end
      quo_nxt = {quo_r[CONV_BITS-2:0], alu_carry};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= '0;
      max_r     <= '0;
      min_idx_r <= '0;
      max_idx_r <= '0;
      best_r    <= '1;
      total_r   <= '0;
    end else begin
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      min_idx_r <= min_idx_nxt;
      max_idx_r <= max_idx_nxt;
      best_r    <= best_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (ctl.mul_en) begin
      thr_r <= total_r * item_rnd;
    end
  end

  assign sts.hit        = ~alu_carry;
  assign sts.total_zero = (total_r == '0);

  assign min_fit  = min_r;
  assign min_idx  = min_idx_r;
  assign max_fit  = max_r;
  assign max_idx  = max_idx_r;
  assign best_fit = best_r;

  // zero minimum gives a full ratio that saturates
  assign conv = (max_r == '0) ? '0 : ((min_r == '0) ? '1 : quo_r);

endmodule

`default_nettype wire

// ===== rtl/rws_ctrl.sv =====
// rws_ctrl: sequencer of the selector: load, table build walk, divide
// steps, draw scan and result hand-off; depends on rws_pkg
`timescale 1ns / 1ps
`default_nettype none

module rws_ctrl
  import rws_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_go,
  input  logic    item_req,
  input  logic    item_last,
  input  logic    out_free,
  input  dp_sts_t sts,
  output logic    busy,
  output dp_ctl_t ctl,
  output res_t    res
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] didx_r, didx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] load_count_r, load_count_nxt;
  logic [CNT_W-1:0] table_count_r, table_count_nxt;
  logic             table_ready_r, table_ready_nxt;
  stat_code_t       code_r, code_nxt;
  logic             summary_r, summary_nxt;

  logic             ovf;
  logic [CNT_W-1:0] lim;
  logic             issue;
  logic             walk_end;
  logic             hit;

  assign ovf      = (load_count_r == CNT_W'(POP_MAX));
  assign lim      = (state_r == ST_SCAN) ? table_count_r : load_count_r;
  assign issue    = (ptr_r < lim);
  assign walk_end = !issue && !pend_r;
  assign hit      = pend_r && sts.hit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_req == REQ_LOAD) begin
          if (item_last) begin
            state_nxt = ST_BUILD;
          end else if (ovf) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (!table_ready_r || sts.total_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_BUILD: begin
        if (walk_end) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == STEP_W'(CONV_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // counters and held result code
  always_comb begin
    ptr_nxt         = ptr_r;
    pend_nxt        = pend_r;
    didx_nxt        = didx_r;
    step_nxt        = step_r;
    load_count_nxt  = load_count_r;
    table_count_nxt = table_count_r;
    table_ready_nxt = table_ready_r;
    code_nxt        = code_r;
    summary_nxt     = summary_r;
    case (state_r)
      ST_EXEC: begin
        ptr_nxt  = '0;
        pend_nxt = 1'b0;
        if (item_req == REQ_LOAD) begin
          if (!ovf) begin
            load_count_nxt = load_count_r + CNT_W'(1);
          end
          code_nxt    = ovf ? STAT_OVERFLOW : STAT_SUMMARY;
          summary_nxt = item_last;
        end else begin
          code_nxt    = table_ready_r ? STAT_ZERO : STAT_NOT_LOADED;
          summary_nxt = 1'b0;
        end
      end
      ST_BUILD: begin
        pend_nxt = issue;
        if (issue) begin
          ptr_nxt  = ptr_r + CNT_W'(1);
          didx_nxt = ptr_r[IDX_W-1:0];
        end
        if (walk_end) begin
          table_count_nxt = load_count_r;
          table_ready_nxt = 1'b1;
          load_count_nxt  = '0;
          step_nxt        = '0;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
        // keep the index of the entry that passed
        if (hit) begin
          code_nxt = STAT_SELECTED;
        end else begin
          if (issue) begin
            didx_nxt = ptr_r[IDX_W-1:0];
          end
          if (walk_end) begin
            code_nxt = STAT_ZERO;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.alu_sel  = SEL_ACC;
    ctl.rd_addr  = ptr_r[IDX_W-1:0];
    ctl.load_idx = load_count_r[IDX_W-1:0];
    ctl.acc_idx  = didx_r;
    res.load     = 1'b0;
    res.code     = code_r;
    res.summary  = summary_r;
    res.sel_idx  = didx_r;
    busy         = (state_r != ST_IDLE);
    case (state_r)
      ST_EXEC: begin
        ctl.load_we = (item_req == REQ_LOAD) && !ovf;
        ctl.first   = (load_count_r == '0);
        ctl.sum_clr = (item_req == REQ_LOAD) && item_last;
      end
      ST_BUILD: begin
        ctl.fit_rd  = issue;
        ctl.acc_en  = pend_r;
        ctl.alu_sel = SEL_ACC;
        ctl.close   = walk_end;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        ctl.alu_sel  = SEL_DIV;
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
      end
      ST_SCAN: begin
        ctl.cum_rd  = issue;
        ctl.alu_sel = SEL_CMP;
      end
      ST_DONE: begin
        res.load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ptr_r         <= '0;
      pend_r        <= 1'b0;
      didx_r        <= '0;
      step_r        <= '0;
      load_count_r  <= '0;
      table_count_r <= '0;
      table_ready_r <= 1'b0;
      code_r        <= STAT_SUMMARY;
      summary_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ptr_r         <= ptr_nxt;
      pend_r        <= pend_nxt;
      didx_r        <= didx_nxt;
      step_r        <= step_nxt;
      load_count_r  <= load_count_nxt;
      table_count_r <= table_count_nxt;
      table_ready_r <= table_ready_nxt;
      code_r        <= code_nxt;
      summary_r     <= summary_nxt;
    end
  end

`ifndef SYNTHESIS
  a_scan_on_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> table_ready_r && table_count_r != '0)
    else $error("draw scan without a built table");

  a_build_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BUILD && pend_r |-> CNT_W'(didx_r) < load_count_r)
    else $error("table build past the loaded values");

  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && code_r == STAT_SELECTED |-> CNT_W'(didx_r) < table_count_r)
    else $error("selected index outside the table");
`endif

endmodule

`default_nettype wire

// ===== rtl/roulette_wheel_selector_top.sv =====
// roulette_wheel_selector_top: item capture, result register and the
// rws_ctrl / rws_dp pair; depends on rws_pkg
`timescale 1ns / 1ps
`default_nettype none

// Roulette wheel selector for a minimizing search. Load items store one
// fitness value each and track min and max; the value marked last closes the
// generation, walks the fitness store once to build the cumulative weights of
// max minus fitness, and runs a 16-step shift/subtract divide for the
// convergence, all on one shared adder. A draw multiplies the total by the
// random fraction, then scans the cumulative store one entry per cycle through
// its single read port. The block takes one item at a time. A finished result
// waits in the output register while the next item is taken. The stores need
// no clearing after reset.
module roulette_wheel_selector_top
  import rws_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [FITNESS_BITS-1:0] in_fitness_value,
  input  logic                    in_last_fitness,
  input  logic [DRAW_BITS-1:0]    in_random_fraction,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       out_status,
  output logic [IDX_W-1:0]        out_selected_index,
  output logic [FITNESS_BITS-1:0] out_min_fitness_out,
  output logic [IDX_W-1:0]        out_min_index_out,
  output logic [FITNESS_BITS-1:0] out_max_fitness_out,
  output logic [IDX_W-1:0]        out_max_index_out,
  output logic [FITNESS_BITS-1:0] out_best_fitness_out,
  output logic [CONV_BITS-1:0]    out_convergence_out
);

  logic                    in_accept;
  logic                    busy;
  logic                    out_free;
  dp_ctl_t                 ctl;
  dp_sts_t                 sts;
  res_t                    res;

  logic                    req_r;
  logic [FITNESS_BITS-1:0] fit_r;
  logic                    last_r;
  logic [DRAW_BITS-1:0]    rnd_r;

  logic [FITNESS_BITS-1:0] min_fit, max_fit, best_fit;
  logic [IDX_W-1:0]        min_idx, max_idx;
  logic [CONV_BITS-1:0]    conv;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       status_r;
  logic [IDX_W-1:0]        sel_idx_r;
  logic [FITNESS_BITS-1:0] min_fit_r, max_fit_r, best_fit_r;
  logic [IDX_W-1:0]        min_idx_r, max_idx_r;
  logic [CONV_BITS-1:0]    conv_r;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r  <= in_req_type;
      fit_r  <= in_fitness_value;
      last_r <= in_last_fitness;
      rnd_r  <= in_random_fraction;
    end
  end

  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_go     (in_accept),
    .item_req  (req_r),
    .item_last (last_r),
    .out_free  (out_free),
    .sts       (sts),
    .busy      (busy),
    .ctl       (ctl),
    .res       (res)
  );

  rws_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .item_fit (fit_r),
    .item_rnd (rnd_r),
    .sts      (sts),
    .min_fit  (min_fit),
    .min_idx  (min_idx),
    .max_fit  (max_fit),
    .max_idx  (max_idx),
    .best_fit (best_fit),
    .conv     (conv)
  );

  assign out_valid_nxt = res.load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // fields that carry no meaning for a result go out as zero
  always_ff @(posedge clk) begin
    if (res.load) begin
      status_r   <= res.code;
      sel_idx_r  <= (res.code == STAT_SELECTED) ? res.sel_idx : '0;
      min_fit_r  <= res.summary ? min_fit : '0;
      min_idx_r  <= res.summary ? min_idx : '0;
      max_fit_r  <= res.summary ? max_fit : '0;
      max_idx_r  <= res.summary ? max_idx : '0;
      best_fit_r <= res.summary ? best_fit : '0;
      conv_r     <= res.summary ? conv : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_selected_index   = sel_idx_r;
  assign out_min_fitness_out  = min_fit_r;
  assign out_min_index_out    = min_idx_r;
  assign out_max_fitness_out  = max_fit_r;
  assign out_max_index_out    = max_idx_r;
  assign out_best_fitness_out = best_fit_r;
  assign out_convergence_out  = conv_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> !out_valid_r || !out_stall)
    else $error("result register overwritten while held");

  a_summary_code: assert property (@(posedge clk) disable iff (!rst_n)
    res.load && res.summary |-> res.code == STAT_SUMMARY || res.code == STAT_OVERFLOW)
    else $error("summary fields on a draw result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("item taken without the sequencer starting");
`endif

endmodule

`default_nettype wire

// ===== dv/roulette_wheel_selector_top_tb.sv =====
`timescale 1ns / 1ps
// roulette_wheel_selector_top_tb: self-checking bench for the roulette wheel selector,
// with a queue-fed driver, a result monitor and a built-in predictor
// depends on rws_pkg and roulette_wheel_selector_top
module roulette_wheel_selector_top_tb;
  import rws_pkg::*;

  localparam int RUN_LIMIT  = 2000000;
  localparam int SHOW_MAX   = 10;
  localparam int RAND_ITEMS = 560;

  typedef struct {
    req_t                    req;
    logic [FITNESS_BITS-1:0] fit;
    logic                    last;
    logic [DRAW_BITS-1:0]    frac;
  } wheel_item_t;

  typedef struct {
    stat_code_t              status;
    logic [IDX_W-1:0]        sel;
    logic [FITNESS_BITS-1:0] min_v;
    logic [IDX_W-1:0]        min_i;
    logic [FITNESS_BITS-1:0] max_v;
    logic [IDX_W-1:0]        max_i;
    logic [FITNESS_BITS-1:0] best_v;
    logic [CONV_BITS-1:0]    conv;
  } wheel_answer_t;

  logic                    clk;
  logic                    rst_n              = 1'b0;
  logic                    in_valid           = 1'b0;
  logic                    in_stall;
  logic                    in_req_type        = 1'b0;
  logic [FITNESS_BITS-1:0] in_fitness_value   = '0;
  logic                    in_last_fitness    = 1'b0;
  logic [DRAW_BITS-1:0]    in_random_fraction = '0;
  logic                    out_valid;
  logic                    out_stall          = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic [IDX_W-1:0]        out_selected_index;
  logic [FITNESS_BITS-1:0] out_min_fitness_out;
  logic [IDX_W-1:0]        out_min_index_out;
  logic [FITNESS_BITS-1:0] out_max_fitness_out;
  logic [IDX_W-1:0]        out_max_index_out;
  logic [FITNESS_BITS-1:0] out_best_fitness_out;
  logic [CONV_BITS-1:0]    out_convergence_out;

  wheel_item_t   pending_items[$];
  wheel_answer_t wheel_answers[$];
  wheel_item_t   drv_item;
  wheel_item_t   next_item;
  wheel_answer_t want;
  int            cycles     = 0;
  int            mismatches = 0;
  int            rand_count = 0;
  bit            quiet;

  // predictor state
  logic [FITNESS_BITS-1:0] fit_mem[POP_MAX];
  logic [CUM_W-1:0]        cum_mem[POP_MAX];
  int                      load_n  = 0;
  int                      table_n = 0;
  bit                      table_ok = 1'b0;
  logic [FITNESS_BITS-1:0] min_v   = '0;
  logic [FITNESS_BITS-1:0] max_v   = '0;
  logic [IDX_W-1:0]        min_i   = '0;
  logic [IDX_W-1:0]        max_i   = '0;
  logic [FITNESS_BITS-1:0] best_v  = '1;
  logic [CUM_W-1:0]        total_w = '0;

  roulette_wheel_selector_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic spin_wheel(input wheel_item_t it);
    wheel_answer_t            a;
    logic [63:0]              ratio;
    logic [CUM_W-1:0]         sum;
    logic [CUM_W+DRAW_BITS-1:0] thr;
    bit                       found;
    a.status = STAT_SUMMARY;
    a.sel    = '0;
    a.min_v  = '0;
    a.min_i  = '0;
    a.max_v  = '0;
    a.max_i  = '0;
    a.best_v = '0;
    a.conv   = '0;
    if (it.req == REQ_LOAD) begin
      if (load_n >= POP_MAX) begin
        a.status = STAT_OVERFLOW;
      end else begin
        fit_mem[load_n] = it.fit;
        if (load_n == 0) begin
          min_v = it.fit;
          max_v = it.fit;
          min_i = '0;
          max_i = '0;
        end else if (it.fit < min_v) begin
          min_v = it.fit;
          min_i = IDX_W'(load_n);
        end else if (it.fit > max_v) begin
          max_v = it.fit;
          max_i = IDX_W'(load_n);
        end
        load_n++;
      end
      if (!it.last) begin
        if (a.status == STAT_OVERFLOW) wheel_answers.insert(wheel_answers.size(), a);
      end else begin
        // close the generation and rebuild the weight table
        if (min_v < best_v) best_v = min_v;
        sum = '0;
        for (int i = 0; i < load_n; i++) begin
          sum = sum + (max_v - fit_mem[i]);
          cum_mem[i] = sum;
        end
        total_w  = sum;
        table_n  = load_n;
        table_ok = 1'b1;
        load_n   = 0;
        if (max_v != 0) begin
          ratio  = ((max_v - min_v) << 16) / max_v;
          a.conv = (ratio > 64'hFFFF) ? 16'hFFFF : ratio[CONV_BITS-1:0];
        end
        a.min_v  = min_v;
        a.min_i  = min_i;
        a.max_v  = max_v;
        a.max_i  = max_i;
        a.best_v = best_v;
        wheel_answers.insert(wheel_answers.size(), a);
      end
    end else begin
      if (!table_ok) begin
        a.status = STAT_NOT_LOADED;
      end else if (total_w == 0) begin
        a.status = STAT_ZERO;
      end else begin
        thr      = total_w * it.frac;
        a.status = STAT_ZERO;
        found    = 1'b0;
        for (int j = 0; j < table_n; j++) begin
          if (!found && {cum_mem[j], {DRAW_BITS{1'b0}}} > thr) begin
            found    = 1'b1;
            a.status = STAT_SELECTED;
            a.sel    = IDX_W'(j);
          end
        end
      end
      wheel_answers.insert(wheel_answers.size(), a);
    end
  endtask

  function automatic void push_load(input logic [FITNESS_BITS-1:0] v, input logic last);
    wheel_item_t it;
    it.req  = REQ_LOAD;
    it.fit  = v;
    it.last = last;
    it.frac = DRAW_BITS'($urandom);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void push_draw(input logic [DRAW_BITS-1:0] r);
    wheel_item_t it;
    it.req  = REQ_DRAW;
    it.fit  = $urandom;
    it.last = 1'($urandom_range(0, 1));
    it.frac = r;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic [DRAW_BITS-1:0] random_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return DRAW_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // one generation of n values, with the odd draw mixed in while loading
  task automatic random_generation(input int n);
    int                      mode;
    logic [FITNESS_BITS-1:0] base;
    logic [FITNESS_BITS-1:0] v;
    mode = $urandom_range(0, 9);
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      if (mode < 5)      v = $urandom;
      else if (mode < 7) v = $urandom_range(1, 8);
      else if (mode < 9) v = base ^ $urandom_range(0, 3);
      else               v = base;
      push_load(v, i == n - 1);
      rand_count++;
      if ($urandom_range(0, 99) < 8) begin
        push_draw(random_frac());
        rand_count++;
      end
    end
  endtask

  task automatic build_stimulus();
    int n;
    // draws with no table yet
    push_draw('0);
    push_draw('1);
    // single value and all-equal generations leave a zero total
    push_load('1, 1'b1);
    push_draw(16'h8000);
    push_load(5, 1'b0);
    push_load(5, 1'b0);
    push_load(5, 1'b1);
    push_draw(16'h1234);
    // ties on min and max keep the first index
    push_load(100, 1'b0);
    push_load(3, 1'b0);
    push_load('1, 1'b0);
    push_load(3, 1'b0);
    push_load('1, 1'b1);
    push_draw('0);
    push_draw('1);
    push_draw(16'h8000);
    push_draw(16'h0001);

    while (rand_count < RAND_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      random_generation(n);
      repeat ($urandom_range(0, 6)) begin
        push_draw(random_frac());
        rand_count++;
      end
    end

    // zero minimum saturates the convergence, zero maximum clears it
    push_load(0, 1'b0);
    push_load('1, 1'b1);
    push_draw(16'hFFFE);
    push_load(0, 1'b0);
    push_load(0, 1'b1);
    push_draw(16'h0007);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("mismatch on %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  assign quiet = (cycles >= 3000) && (cycles < 12000);

  // driver
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) spin_wheel(drv_item);
      if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
        next_item          = pending_items.pop_front();
        drv_item           <= next_item;
        in_req_type        <= next_item.req;
        in_fitness_value   <= next_item.fit;
        in_last_fitness    <= next_item.last;
        in_random_fraction <= next_item.frac;
        in_valid           <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 11);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (wheel_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected item: status %0d index %0d", out_status, out_selected_index);
      end else begin
        want = wheel_answers.pop_front();
        check_field("status", want.status, out_status);
        check_field("selected_index", want.sel, out_selected_index);
        check_field("min_value", want.min_v, out_min_fitness_out);
        check_field("min_index", want.min_i, out_min_index_out);
        check_field("max_value", want.max_v, out_max_fitness_out);
        check_field("max_index", want.max_i, out_max_index_out);
        check_field("best_value", want.best_v, out_best_fitness_out);
        check_field("convergence", want.conv, out_convergence_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid || wheel_answers.size() != 0)
      @(posedge clk);
    // a last load that builds a full table is the longest the block can stay busy
    repeat (POP_MAX + 100) @(posedge clk);
    if (mismatches == 0 && wheel_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
